[rtl/newline_offset_line_locator_assert.svh]
// Assertion macros shared by the line locator checker.
// No dependencies; include by bare file name.
`ifndef NEWLINE_OFFSET_LINE_LOCATOR_ASSERT_SVH
`define NEWLINE_OFFSET_LINE_LOCATOR_ASSERT_SVH

// same-cycle implication
`define NOL_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("nol check failed");

// next-cycle implication
`define NOL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("nol check failed");

`endif

[rtl/nol_pkg.sv]
// Package for the newline offset line locator: sizes, codes and field widths.
// No dependencies.
package nol_pkg;

    localparam int MAX_LINES = 4096;
    localparam int POS_BITS  = 24;

    localparam int ADDR_BITS = (MAX_LINES > 2) ? $clog2(MAX_LINES) : 1;
    localparam int CNT_BITS  = ADDR_BITS + 1;
    localparam int STEP_BITS = (ADDR_BITS > 1) ? $clog2(ADDR_BITS) : 1;

    localparam int LINE_W  = 12;
    localparam int COL_W   = 24;
    localparam int STAT_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int IN_DW   = 32;
    localparam int OUT_DW  = 40;

    localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

    typedef enum logic {
        ACT_SCAN   = 1'b0,
        ACT_LOCATE = 1'b1
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_ORDER = 2'd2
    } t_status;

endpackage

[rtl/newline_offset_line_locator.sv]
// Top level of the newline offset line locator: line-start table and search.
// Depends on nol_pkg.
//
// A scan transfer appends position+1 to the line-start table when its byte is
// a newline, the table is not full and position+1 lies past the last start;
// a locate transfer runs a one-read-per-cycle binary search over the single
// read port of the table memory, one index bit resolved per read. Both then
// pass through S_DONE to the output register. One item is in work at a time;
// a finished result sits in the output register while the next item is
// accepted. No clearing pass is needed after reset.
module newline_offset_line_locator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [nol_pkg::IN_DW-1:0]  s_axis_tdata,  // position[23:0], text_byte[31:24]
    input  logic                       s_axis_tuser,  // action
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [nol_pkg::OUT_DW-1:0] m_axis_tdata   // line[11:0], column[35:12],
                                                      // status[37:36], zero[39:38]
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SRCH,
        S_DONE
    } t_state;

    localparam int AW = nol_pkg::ADDR_BITS;
    localparam int PW = nol_pkg::POS_BITS;
    localparam int CW = nol_pkg::CNT_BITS;
    localparam int SW = nol_pkg::STEP_BITS;

    logic [PW-1:0] r_mem [nol_pkg::MAX_LINES];
    logic [PW-1:0] r_rdata;

    t_state                     r_state;
    logic [CW-1:0]              r_cnt;
    logic [PW-1:0]              r_last;
    logic [PW-1:0]              r_pos;
    logic [AW-1:0]              r_idx;
    logic [PW-1:0]              r_base;
    logic [AW-1:0]              r_cand;
    logic [SW-1:0]              r_bit;
    logic [nol_pkg::LINE_W-1:0] r_p_line;
    logic [nol_pkg::COL_W-1:0]  r_p_col;
    nol_pkg::t_status           r_p_status;
    logic                       r_m_valid;
    logic [nol_pkg::OUT_DW-1:0] r_m_data;

    logic                       in_acc;
    logic [PW-1:0]              in_pos;
    logic [nol_pkg::BYTE_W-1:0] in_byte;
    logic [PW-1:0]              next_start;
    logic                       is_nl;
    logic                       tbl_full;
    logic                       not_incr;
    logic                       mem_we;
    logic                       hit;
    logic [AW-1:0]              srch_idx;
    logic [PW-1:0]              srch_base;
    logic [AW-1:0]              step_mask;
    logic [AW-1:0]              rd_addr;
    logic                       out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_pos        = PW'(s_axis_tdata[23:0]);
    assign in_byte       = s_axis_tdata[31:24];
    assign next_start    = in_pos + PW'(1);
    assign is_nl         = (in_byte == nol_pkg::NEWLINE);
    assign tbl_full      = (r_cnt >= CW'(nol_pkg::MAX_LINES));
    assign not_incr      = (next_start <= r_last);
    assign mem_we        = in_acc && (s_axis_tuser == nol_pkg::ACT_SCAN) && is_nl
                           && !tbl_full && !not_incr;

    // candidate is accepted only when inside the filled part and not past pos
    assign hit       = ({1'b0, r_cand} < r_cnt) && (r_rdata <= r_pos);
    assign srch_idx  = hit ? r_cand : r_idx;
    assign srch_base = hit ? r_rdata : r_base;
    assign step_mask = AW'(1) << (r_bit - SW'(1));
    assign rd_addr   = (r_state == S_SRCH) ? (srch_idx | step_mask)
                                           : (AW'(1) << (AW - 1));
    assign out_free  = !r_m_valid || m_axis_tready;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_cnt[AW-1:0]] <= next_start;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= CW'(1);
            r_last    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (r_m_valid && m_axis_tready && (r_state != S_DONE)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_pos      <= in_pos;
                        r_p_line   <= '0;
                        r_p_col    <= '0;
                        r_p_status <= nol_pkg::ST_OK;
                        if (s_axis_tuser == nol_pkg::ACT_LOCATE) begin
                            r_idx   <= '0;
                            r_base  <= '0;
                            r_cand  <= rd_addr;
                            r_bit   <= SW'(AW - 1);
                            r_state <= S_SRCH;
                        end else begin
                            if (is_nl) begin
                                if (tbl_full) begin
                                    r_p_status <= nol_pkg::ST_FULL;
                                end else if (not_incr) begin
                                    r_p_status <= nol_pkg::ST_ORDER;
                                end else begin
                                    r_cnt  <= r_cnt + CW'(1);
                                    r_last <= next_start;
                                end
                            end
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SRCH: begin
                    r_idx  <= srch_idx;
                    r_base <= srch_base;
                    if (r_bit == '0) begin
                        r_p_line <= nol_pkg::LINE_W'(srch_idx);
                        r_p_col  <= nol_pkg::COL_W'(r_pos - srch_base);
                        r_state  <= S_DONE;
                    end else begin
                        r_cand <= rd_addr;
                        r_bit  <= r_bit - SW'(1);
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {2'b00, r_p_status, r_p_col, r_p_line};
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/nol_checker.sv]
// Port-level checker for the newline offset line locator, bound to the top.
// Depends on nol_pkg and newline_offset_line_locator_assert.svh.
`include "newline_offset_line_locator_assert.svh"

module nol_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [nol_pkg::OUT_DW-1:0] m_axis_tdata
);

    logic [1:0] stat;
    logic       out_wait;
    logic       in_xfer;
    logic       stat_known;
    logic       dropped;
    logic       body_zero;

    assign stat       = m_axis_tdata[37:36];
    assign out_wait   = m_axis_tvalid && !m_axis_tready;
    assign in_xfer    = s_axis_tvalid && s_axis_tready;
    assign stat_known = (stat == nol_pkg::ST_OK) || (stat == nol_pkg::ST_FULL)
                        || (stat == nol_pkg::ST_ORDER);
    assign dropped    = m_axis_tvalid && (stat != nol_pkg::ST_OK);
    assign body_zero  = (m_axis_tdata[35:0] == 36'd0);

    `NOL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, m_axis_tvalid && $stable(m_axis_tdata))
    `NOL_ASSERT_NOW(a_stat_code, i_clk, i_rst_n, m_axis_tvalid, stat_known)
    `NOL_ASSERT_NOW(a_drop_zero, i_clk, i_rst_n, dropped, body_zero)
    `NOL_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, in_xfer, !s_axis_tready)

endmodule

bind newline_offset_line_locator nol_checker u_nol_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
